[rtl/core/srfa_pkg.sv]
// Shared types, widths and constants of the scan repulsive force accumulator.
`default_nettype none
package srfa_pkg;

	localparam int unsigned RISK_THRESHOLD = 10;

	localparam int unsigned DIV_NUM_W   = 57;
	localparam int unsigned DIV_DEN_W   = 38;
	localparam int unsigned DIV_CNT_W   = 6;
	localparam int unsigned SQRT_RAD_W  = 50;
	localparam int unsigned SQRT_ROOT_W = 25;
	localparam int unsigned SQRT_CNT_W  = 5;
	localparam int unsigned MUL_A_W     = 41;
	localparam int unsigned MUL_B_W     = 23;
	localparam int unsigned PROD_W      = MUL_A_W + MUL_B_W;
	localparam int unsigned SUM_W       = 48;
	localparam int unsigned CFG_IDX_W   = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_BOX_MIN_X    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_MAX_X = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BOX_MIN_Y    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BOX_MAX_Y    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BOX_MIN_Z    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_BOX_MAX_Z    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_INFL_RADIUS  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_REPUL_GAIN   = 3'd7;

	typedef struct packed {
		logic signed [15:0] point_x;
		logic signed [15:0] point_y;
		logic signed [15:0] point_z;
		logic               last_point;
	} point_item_t;

	typedef struct packed {
		logic               risk_flag;
		logic signed [31:0] mean_force_x;
		logic signed [31:0] mean_force_y;
		logic        [15:0] box_points;
	} result_item_t;

	typedef enum logic [2:0] {
		MUL_X, MUL_Y, MUL_Z, MUL_D0SQ, MUL_DEN, MUL_MAG, MUL_CX, MUL_CY
	} mul_sel_t;

	typedef enum logic [1:0] {
		DIV_INNER, DIV_COMP, DIV_MEAN_X, DIV_MEAN_Y
	} div_sel_t;

	typedef enum logic {
		RAD_DIST, RAD_INNER
	} rad_sel_t;

	typedef struct packed {
		logic     load_point;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     s_first;
		logic     s_acc;
		logic     sqrt_start;
		rad_sel_t rad_sel;
		logic     dq_load;
		logic     div_start;
		div_sel_t div_sel;
		logic     mag_load;
		logic     sum_x_upd;
		logic     sum_y_upd;
		logic     mean_x_load;
		logic     mean_y_load;
		logic     out_load;
	} srfa_cmd_t;

	typedef struct packed {
		logic force_ok;
		logic last;
		logic sqrt_done;
		logic div_done;
		logic out_free;
	} srfa_sts_t;

endpackage
`default_nettype wire

[rtl/core/srfa_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module srfa_div
	import srfa_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [DIV_NUM_W-1:0] num,
	input  wire logic [DIV_DEN_W-1:0] den,
	output logic                      done,
	output logic      [DIV_NUM_W-1:0] quo
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_NUM_W-1:0] quo_q;
	logic [DIV_DEN_W:0]   shifted;
	logic [DIV_DEN_W:0]   diff;
	logic                 ge;
	logic [DIV_DEN_W-1:0] rem_nx;

	always_comb begin
		shifted = {rem_q, quo_q[DIV_NUM_W-1]};
		diff    = shifted - {1'b0, den_q};
		ge      = shifted >= {1'b0, den_q};
		rem_nx  = ge ? diff[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			quo_q <= {quo_q[DIV_NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule
`default_nettype wire

[rtl/core/srfa_sqrt.sv]
// Digit-recurrence integer square root, one root bit per cycle.
`default_nettype none
module srfa_sqrt
	import srfa_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire logic [SQRT_RAD_W-1:0]  rad,
	output logic                        done,
	output logic      [SQRT_ROOT_W-1:0] root
);

	logic                    busy_q;
	logic                    done_q;
	logic [SQRT_CNT_W-1:0]   cnt_q;
	logic [SQRT_RAD_W-1:0]   rad_q;
	logic [SQRT_ROOT_W-1:0]  root_q;
	logic [SQRT_ROOT_W:0]    rem_q;
	logic [SQRT_ROOT_W+2:0]  shifted;
	logic [SQRT_ROOT_W+2:0]  trial;
	logic [SQRT_ROOT_W+2:0]  diff;
	logic                    ge;
	logic [SQRT_ROOT_W:0]    rem_nx;

	always_comb begin
		shifted = {rem_q, rad_q[SQRT_RAD_W-1 -: 2]};
		trial   = {1'b0, root_q, 2'b01};
		diff    = shifted - trial;
		ge      = shifted >= trial;
		rem_nx  = ge ? diff[SQRT_ROOT_W:0] : shifted[SQRT_ROOT_W:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == SQRT_CNT_W'(SQRT_ROOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= rad;
			root_q <= '0;
			rem_q  <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[SQRT_RAD_W-3:0], 2'b00};
			root_q <= {root_q[SQRT_ROOT_W-2:0], ge};
			rem_q  <= rem_nx;
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule
`default_nettype wire

[rtl/core/srfa_dp.sv]
// Datapath: configuration, box count, shared multiplier, divider, square root, sums, result.
`default_nettype none
module srfa_dp
	import srfa_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire srfa_cmd_t            cmd,
	output srfa_sts_t                 sts,
	input  wire point_item_t          point,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [15:0]          cfg_data,
	output logic                      result_valid,
	input  wire logic                 result_stall,
	output result_item_t              result
);

	logic signed [15:0] box_min_x_q, search_max_x_q, box_min_y_q;
	logic signed [15:0] box_max_y_q, box_min_z_q, box_max_z_q;
	logic [14:0]        d0_q;
	logic [15:0]        gain_q;

	logic [15:0]          ax_q, ay_q, az_q;
	logic                 negx_q, negy_q, last_q;
	logic [31:0]          s_q;
	logic [PROD_W-1:0]    p_q;
	logic [22:0]          dq_q;
	logic [MUL_A_W-1:0]   mag_q;
	logic [SUM_W-1:0]     sum_x_q, sum_y_q;
	logic [15:0]          fpts_q, inside_q;
	logic [31:0]          mean_x_q, mean_y_q;
	logic                 out_valid_q;
	result_item_t         out_q;

	logic [MUL_A_W-1:0]     mul_a;
	logic [MUL_B_W-1:0]     mul_b;
	logic [PROD_W-1:0]      prod;
	logic                   in_box;
	logic [15:0]            abs_x, abs_y, abs_z;
	logic [22:0]            d_diff;
	logic [32:0]            d_diff_k;
	logic [DIV_NUM_W-1:0]   div_num;
	logic [DIV_DEN_W-1:0]   div_den;
	logic                   div_done;
	logic [DIV_NUM_W-1:0]   div_quo;
	logic [SQRT_RAD_W-1:0]  sq_rad;
	logic                   sq_done;
	logic [SQRT_ROOT_W-1:0] sq_root;
	logic [SUM_W-1:0]       q48;
	logic [SUM_W-1:0]       abs_sum_x, abs_sum_y;
	logic                   mean_neg;
	logic [31:0]            mean_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_min_x_q    <= 16'sd300;
			search_max_x_q <= 16'sd800;
			box_min_y_q    <= -16'sd300;
			box_max_y_q    <= 16'sd300;
			box_min_z_q    <= 16'sd50;
			box_max_z_q    <= 16'sd1500;
			d0_q           <= 15'd1000;
			gain_q         <= 16'd256;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BOX_MIN_X:    box_min_x_q    <= cfg_data;
				CFG_SEARCH_MAX_X: search_max_x_q <= cfg_data;
				CFG_BOX_MIN_Y:    box_min_y_q    <= cfg_data;
				CFG_BOX_MAX_Y:    box_max_y_q    <= cfg_data;
				CFG_BOX_MIN_Z:    box_min_z_q    <= cfg_data;
				CFG_BOX_MAX_Z:    box_max_z_q    <= cfg_data;
				CFG_INFL_RADIUS:  d0_q           <= cfg_data[14:0];
				CFG_REPUL_GAIN:   gain_q         <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		abs_x  = point.point_x[15] ? 16'(-point.point_x) : point.point_x;
		abs_y  = point.point_y[15] ? 16'(-point.point_y) : point.point_y;
		abs_z  = point.point_z[15] ? 16'(-point.point_z) : point.point_z;
		in_box = (point.point_x > box_min_x_q) && (point.point_x < search_max_x_q) &&
		         (point.point_y > box_min_y_q) && (point.point_y < box_max_y_q) &&
		         (point.point_z > box_min_z_q) && (point.point_z < box_max_z_q);
	end

	always_comb begin
		unique case (cmd.mul_sel)
			MUL_X:    begin mul_a = {25'b0, ax_q};    mul_b = {7'b0, ax_q};   end
			MUL_Y:    begin mul_a = {25'b0, ay_q};    mul_b = {7'b0, ay_q};   end
			MUL_Z:    begin mul_a = {25'b0, az_q};    mul_b = {7'b0, az_q};   end
			MUL_D0SQ: begin mul_a = {26'b0, d0_q};    mul_b = {8'b0, d0_q};   end
			MUL_DEN:  begin mul_a = {18'b0, dq_q};    mul_b = {8'b0, d0_q};   end
			MUL_MAG:  begin mul_a = {16'b0, sq_root}; mul_b = {7'b0, gain_q}; end
			MUL_CX:   begin mul_a = mag_q;            mul_b = {7'b0, ax_q};   end
			MUL_CY:   begin mul_a = mag_q;            mul_b = {7'b0, ay_q};   end
			default:  begin mul_a = '0;               mul_b = '0;             end
		endcase
		prod = mul_a * mul_b;
	end

	always_comb begin
		abs_sum_x = sum_x_q[SUM_W-1] ? (~sum_x_q + 1'b1) : sum_x_q;
		abs_sum_y = sum_y_q[SUM_W-1] ? (~sum_y_q + 1'b1) : sum_y_q;
		d_diff    = {d0_q, 8'b0} - dq_q;
		d_diff_k  = 33'(d_diff) * 33'd1000;
		unique case (cmd.div_sel)
			DIV_INNER: begin
				div_num = {d_diff_k, 24'b0};
				div_den = p_q[DIV_DEN_W-1:0];
			end
			DIV_COMP: begin
				div_num = {p_q[48:0], 8'b0} + {31'b0, dq_q, 3'b0};
				div_den = {11'b0, dq_q, 4'b0};
			end
			DIV_MEAN_X: begin
				div_num = {9'b0, abs_sum_x};
				div_den = {22'b0, fpts_q};
			end
			DIV_MEAN_Y: begin
				div_num = {9'b0, abs_sum_y};
				div_den = {22'b0, fpts_q};
			end
			default: begin
				div_num = '0;
				div_den = '0;
			end
		endcase
		sq_rad = (cmd.rad_sel == RAD_DIST) ? {4'b0, s_q[29:0], 16'b0} : div_quo[SQRT_RAD_W-1:0];
	end

	srfa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	srfa_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.sqrt_start),
		.rad    (sq_rad),
		.done   (sq_done),
		.root   (sq_root)
	);

	always_comb begin
		q48      = div_quo[SUM_W-1:0];
		mean_neg = cmd.mean_x_load ? sum_x_q[SUM_W-1] : sum_y_q[SUM_W-1];
		if (fpts_q == 16'd0) begin
			mean_val = '0;
		end else if (!mean_neg) begin
			mean_val = (q48[SUM_W-1:31] != '0) ? 32'h7FFF_FFFF : {1'b0, q48[30:0]};
		end else begin
			mean_val = (q48 > 48'h0000_8000_0000) ? 32'h8000_0000 : 32'(-q48[31:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_point) begin
			ax_q   <= abs_x;
			ay_q   <= abs_y;
			az_q   <= abs_z;
			negx_q <= point.point_x[15];
			negy_q <= point.point_y[15];
			last_q <= point.last_point;
		end
		if (cmd.mul_en) begin
			p_q <= prod;
		end
		if (cmd.s_first) begin
			s_q <= p_q[31:0];
		end else if (cmd.s_acc) begin
			s_q <= s_q + p_q[31:0];
		end
		if (cmd.dq_load) begin
			dq_q <= sq_root[22:0];
		end
		if (cmd.mag_load) begin
			mag_q <= p_q[MUL_A_W-1:0];
		end
		if (cmd.mean_x_load) begin
			mean_x_q <= mean_val;
		end
		if (cmd.mean_y_load) begin
			mean_y_q <= mean_val;
		end
		if (cmd.out_load) begin
			out_q.risk_flag    <= inside_q > 16'(RISK_THRESHOLD);
			out_q.mean_force_x <= mean_x_q;
			out_q.mean_force_y <= mean_y_q;
			out_q.box_points   <= inside_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_x_q     <= '0;
			sum_y_q     <= '0;
			fpts_q      <= '0;
			inside_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				sum_x_q     <= '0;
				sum_y_q     <= '0;
				fpts_q      <= '0;
				inside_q    <= '0;
				out_valid_q <= 1'b1;
			end else begin
				if (!result_stall) begin
					out_valid_q <= 1'b0;
				end
				if (cmd.load_point && in_box && inside_q != 16'hFFFF) begin
					inside_q <= inside_q + 1'b1;
				end
				if (cmd.sum_x_upd) begin
					sum_x_q <= negx_q ? sum_x_q + q48 : sum_x_q - q48;
				end
				if (cmd.sum_y_upd) begin
					sum_y_q <= negy_q ? sum_y_q + q48 : sum_y_q - q48;
					fpts_q  <= fpts_q + 1'b1;
				end
			end
		end
	end

	always_comb begin
		sts.force_ok  = (s_q != 32'd0) && (s_q < {2'b0, p_q[29:0]}) && (fpts_q != 16'hFFFF);
		sts.last      = last_q;
		sts.sqrt_done = sq_done;
		sts.div_done  = div_done;
		sts.out_free  = !out_valid_q || !result_stall;
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule
`default_nettype wire

[rtl/core/srfa_ctrl.sv]
// Controller: sequences the datapath through one point and the end-of-scan result.
`default_nettype none
module srfa_ctrl
	import srfa_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      point_valid,
	output logic           point_stall,
	input  wire srfa_sts_t sts,
	output srfa_cmd_t      cmd
);

	typedef enum logic [22:0] {
		ST_IDLE = 23'd1 << 0,
		ST_MX   = 23'd1 << 1,
		ST_MY   = 23'd1 << 2,
		ST_MZ   = 23'd1 << 3,
		ST_MD   = 23'd1 << 4,
		ST_CHK  = 23'd1 << 5,
		ST_SQ1  = 23'd1 << 6,
		ST_MDEN = 23'd1 << 7,
		ST_DS   = 23'd1 << 8,
		ST_DV1  = 23'd1 << 9,
		ST_SQ2  = 23'd1 << 10,
		ST_MMAG = 23'd1 << 11,
		ST_MAGH = 23'd1 << 12,
		ST_MCX  = 23'd1 << 13,
		ST_DCXS = 23'd1 << 14,
		ST_DCX  = 23'd1 << 15,
		ST_MCY  = 23'd1 << 16,
		ST_DCYS = 23'd1 << 17,
		ST_DCY  = 23'd1 << 18,
		ST_FIN  = 23'd1 << 19,
		ST_DMX  = 23'd1 << 20,
		ST_DMY  = 23'd1 << 21,
		ST_OUT  = 23'd1 << 22
	} state_t;

	state_t state_q, state_nx;

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		cmd.mul_sel = MUL_X;
		cmd.div_sel = DIV_INNER;
		cmd.rad_sel = RAD_DIST;
		unique case (state_q)
			ST_IDLE: begin
				if (point_valid) begin
					cmd.load_point = 1'b1;
					state_nx = ST_MX;
				end
			end
			ST_MX: begin
				cmd.mul_en = 1'b1; cmd.mul_sel = MUL_X;
				state_nx = ST_MY;
			end
			ST_MY: begin
				cmd.s_first = 1'b1;
				cmd.mul_en = 1'b1; cmd.mul_sel = MUL_Y;
				state_nx = ST_MZ;
			end
			ST_MZ: begin
				cmd.s_acc = 1'b1;
				cmd.mul_en = 1'b1; cmd.mul_sel = MUL_Z;
				state_nx = ST_MD;
			end
			ST_MD: begin
				cmd.s_acc = 1'b1;
				cmd.mul_en = 1'b1; cmd.mul_sel = MUL_D0SQ;
				state_nx = ST_CHK;
			end
			ST_CHK: begin
				if (sts.force_ok) begin
					cmd.sqrt_start = 1'b1; cmd.rad_sel = RAD_DIST;
					state_nx = ST_SQ1;
				end else begin
					state_nx = ST_FIN;
				end
			end
			ST_SQ1: begin
				if (sts.sqrt_done) begin
					cmd.dq_load = 1'b1;
					state_nx = ST_MDEN;
				end
			end
			ST_MDEN: begin
				cmd.mul_en = 1'b1; cmd.mul_sel = MUL_DEN;
				state_nx = ST_DS;
			end
			ST_DS: begin
				cmd.div_start = 1'b1; cmd.div_sel = DIV_INNER;
				state_nx = ST_DV1;
			end
			ST_DV1: begin
				if (sts.div_done) begin
					cmd.sqrt_start = 1'b1; cmd.rad_sel = RAD_INNER;
					state_nx = ST_SQ2;
				end
			end
			ST_SQ2: begin
				if (sts.sqrt_done) begin
					state_nx = ST_MMAG;
				end
			end
			ST_MMAG: begin
				cmd.mul_en = 1'b1; cmd.mul_sel = MUL_MAG;
				state_nx = ST_MAGH;
			end
			ST_MAGH: begin
				cmd.mag_load = 1'b1;
				state_nx = ST_MCX;
			end
			ST_MCX: begin
				cmd.mul_en = 1'b1; cmd.mul_sel = MUL_CX;
				state_nx = ST_DCXS;
			end
			ST_DCXS: begin
				cmd.div_start = 1'b1; cmd.div_sel = DIV_COMP;
				state_nx = ST_DCX;
			end
			ST_DCX: begin
				if (sts.div_done) begin
					cmd.sum_x_upd = 1'b1;
					state_nx = ST_MCY;
				end
			end
			ST_MCY: begin
				cmd.mul_en = 1'b1; cmd.mul_sel = MUL_CY;
				state_nx = ST_DCYS;
			end
			ST_DCYS: begin
				cmd.div_start = 1'b1; cmd.div_sel = DIV_COMP;
				state_nx = ST_DCY;
			end
			ST_DCY: begin
				if (sts.div_done) begin
					cmd.sum_y_upd = 1'b1;
					state_nx = ST_FIN;
				end
			end
			ST_FIN: begin
				if (sts.last) begin
					cmd.div_start = 1'b1; cmd.div_sel = DIV_MEAN_X;
					state_nx = ST_DMX;
				end else begin
					state_nx = ST_IDLE;
				end
			end
			ST_DMX: begin
				cmd.div_sel = DIV_MEAN_X;
				if (sts.div_done) begin
					cmd.mean_x_load = 1'b1;
					cmd.div_start = 1'b1; cmd.div_sel = DIV_MEAN_Y;
					state_nx = ST_DMY;
				end
			end
			ST_DMY: begin
				cmd.div_sel = DIV_MEAN_Y;
				if (sts.div_done) begin
					cmd.mean_y_load = 1'b1;
					state_nx = ST_OUT;
				end
			end
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	assign point_stall = (state_q != ST_IDLE);

endmodule
`default_nettype wire

[rtl/core/scan_repulsive_force_accumulator.sv]
// Top level of the scan repulsive force accumulator.
// One point at a time: a point outside the influence radius (or at the origin) skips the
// force path after the squared-distance check; a force point is dominated by the shared
// one-bit-per-cycle divider (for the inverse-distance term and the two force components)
// and the square root unit (used twice). The last point of a scan adds the two mean
// divisions before the result item is loaded into the output register; a new point is
// taken while that result still waits. Configuration writes are accepted every cycle.
`default_nettype none
module scan_repulsive_force_accumulator
	import srfa_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 point_valid,
	output logic                      point_stall,
	input  wire point_item_t          point,
	output logic                      result_valid,
	input  wire logic                 result_stall,
	output result_item_t              result,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [15:0]          cfg_data
);

	srfa_cmd_t cmd;
	srfa_sts_t sts;

	assign cfg_ready = 1'b1;

	srfa_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.point_valid (point_valid),
		.point_stall (point_stall),
		.sts         (sts),
		.cmd         (cmd)
	);

	srfa_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.point        (point),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
`default_nettype wire

[rtl/core/srfa_checker.sv]
// Port-level checks of the scan repulsive force accumulator and their binding.
`default_nettype none
module srfa_checker
	import srfa_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 point_valid,
	input wire logic                 point_stall,
	input wire logic                 result_valid,
	input wire logic                 result_stall,
	input wire result_item_t         result,
	input wire logic                 cfg_valid,
	input wire logic                 cfg_ready
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result item changed or dropped");

	a_busy_after_point: assert property (@(posedge clk) disable iff (!arst_n)
		point_valid && !point_stall |=> point_stall)
		else $error("point taken on consecutive cycles");

	a_risk_flag: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.risk_flag == (result.box_points > 16'(RISK_THRESHOLD)))
		else $error("risk flag disagrees with box count");

	a_cfg_always_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind scan_repulsive_force_accumulator srfa_checker u_srfa_checker (.*);
`default_nettype wire

[dv/scan_repulsive_force_accumulator_test.sv]
// Testbench for the scan repulsive force accumulator: scan stimulus, force prediction, checking.
`default_nettype none
module scan_repulsive_force_accumulator_test;
	timeunit 1ns;
	timeprecision 1ps;
	import srfa_pkg::*;

	class force_scoreboard;
		shortint box_lo_x, box_hi_x, box_lo_y, box_hi_y, box_lo_z, box_hi_z;
		int unsigned radius_mm, gain_q8;
		longint sum_fx, sum_fy;
		int unsigned n_force, n_box;
		result_item_t expected_results[$];
		int mismatches;

		function new();
			box_lo_x = 300; box_hi_x = 800; box_lo_y = -300; box_hi_y = 300;
			box_lo_z = 50; box_hi_z = 1500; radius_mm = 1000; gain_q8 = 256;
			sum_fx = 0; sum_fy = 0; n_force = 0; n_box = 0; mismatches = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
			case (idx)
				CFG_BOX_MIN_X:    box_lo_x = val;
				CFG_SEARCH_MAX_X: box_hi_x = val;
				CFG_BOX_MIN_Y:    box_lo_y = val;
				CFG_BOX_MAX_Y:    box_hi_y = val;
				CFG_BOX_MIN_Z:    box_lo_z = val;
				CFG_BOX_MAX_Z:    box_hi_z = val;
				CFG_INFL_RADIUS:  radius_mm = 32'(val[14:0]);
				CFG_REPUL_GAIN:   gain_q8 = 32'(val);
				default: ;
			endcase
		endfunction

		function longint unsigned int_root(longint unsigned v);
			longint unsigned res, bitv;
			res = 0;
			bitv = 64'd1 << 62;
			while (bitv > v) bitv >>= 2;
			while (bitv != 0) begin
				if (v >= res + bitv) begin
					v -= res + bitv;
					res = (res >> 1) + bitv;
				end else begin
					res >>= 1;
				end
				bitv >>= 2;
			end
			return res;
		endfunction

		function longint push_component(longint unsigned mag, int c, longint unsigned den);
			longint unsigned ac, q;
			ac = (c < 0) ? longint'(-c) : longint'(c);
			q = (mag * ac * 256 + den / 2) / den;
			return (c < 0) ? longint'(q) : -longint'(q);
		endfunction

		function logic signed [31:0] mean_force(longint sum, int unsigned n);
			longint m;
			if (n == 0) return 0;
			m = sum / longint'(n);
			if (m > 64'sd2147483647) m = 64'sd2147483647;
			if (m < -64'sd2147483648) m = -64'sd2147483648;
			return m[31:0];
		endfunction

		function void note_point(point_item_t p);
			int x, y, z;
			longint unsigned s, d0, dq, inner, mag, den;
			result_item_t r;
			x = int'(p.point_x); y = int'(p.point_y); z = int'(p.point_z);
			s = longint'(x) * x + longint'(y) * y + longint'(z) * z;
			d0 = 64'(radius_mm);
			if (x > box_lo_x && x < box_hi_x && y > box_lo_y && y < box_hi_y &&
					z > box_lo_z && z < box_hi_z && n_box < 65535)
				n_box++;
			if (s != 0 && s < d0 * d0 && n_force < 65535) begin
				dq = int_root(s << 16);
				inner = ((1000 * (256 * d0 - dq)) << 24) / (dq * d0);
				mag = longint'(gain_q8) * int_root(inner);
				den = dq * 16;
				sum_fx += push_component(mag, x, den);
				sum_fy += push_component(mag, y, den);
				n_force++;
			end
			if (p.last_point) begin
				r.risk_flag = n_box > RISK_THRESHOLD;
				r.mean_force_x = mean_force(sum_fx, n_force);
				r.mean_force_y = mean_force(sum_fy, n_force);
				r.box_points = n_box[15:0];
				expected_results = {expected_results, r};
				sum_fx = 0; sum_fy = 0; n_force = 0; n_box = 0;
			end
		endfunction

		task report(string what, longint exp_v, longint got_v);
			mismatches++;
			$display("mismatch %s: expected %0d got %0d at %0t", what, exp_v, got_v, $realtime);
		endtask

		task check_result(result_item_t got);
			result_item_t e;
			if (expected_results.size() == 0) begin
				report("unexpected result item", 0, longint'(got.box_points));
				return;
			end
			e = expected_results.pop_front();
			if (got.risk_flag !== e.risk_flag)
				report("risk_flag", longint'(e.risk_flag), longint'(got.risk_flag));
			if (got.mean_force_x !== e.mean_force_x)
				report("mean_force_x", longint'(e.mean_force_x), longint'(got.mean_force_x));
			if (got.mean_force_y !== e.mean_force_y)
				report("mean_force_y", longint'(e.mean_force_y), longint'(got.mean_force_y));
			if (got.box_points !== e.box_points)
				report("box_points", longint'(e.box_points), longint'(got.box_points));
		endtask
	endclass

	logic clk, arst_n;
	logic point_valid, point_stall;
	point_item_t point;
	logic result_valid, result_stall;
	result_item_t result;
	logic cfg_valid, cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [15:0] cfg_data;

	force_scoreboard sb;
	logic pt_take, res_take, cfg_take;
	point_item_t pt_seen;
	result_item_t res_seen;
	bit calm, hold_req;
	int idle_cycles;

	scan_repulsive_force_accumulator DUT (
		.clk(clk), .arst_n(arst_n),
		.point_valid(point_valid), .point_stall(point_stall), .point(point),
		.result_valid(result_valid), .result_stall(result_stall), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	always @(negedge clk) begin
		pt_take <= arst_n && point_valid && !point_stall;
		res_take <= arst_n && result_valid && !result_stall;
		cfg_take <= arst_n && cfg_valid && cfg_ready;
		pt_seen <= point;
		res_seen <= result;
	end

	always @(posedge clk) begin
		if (pt_take) sb.note_point(pt_seen);
		if (res_take) sb.check_result(res_seen);
	end

	always @(posedge clk) begin
		if (pt_take || res_take || cfg_take || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		int run, r;
		result_stall = 0;
		run = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 0;
				result_stall <= 1;
				repeat (3000) @(posedge clk);
				result_stall <= 0;
				run = 0;
			end else if (run > 0) begin
				run--;
			end else if (calm) begin
				result_stall <= 0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 65) begin
					result_stall <= 0;
					run = $urandom_range(0, 10);
				end else if (r < 95) begin
					result_stall <= 1;
					run = $urandom_range(0, 4);
				end else begin
					result_stall <= 1;
					run = $urandom_range(20, 80);
				end
			end
		end
	end

	task automatic send_point(input point_item_t p);
		int gap, r;
		point <= p;
		point_valid <= 1;
		@(posedge clk);
		while (!pt_take) @(posedge clk);
		r = $urandom_range(0, 99);
		gap = calm ? 0 : (r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 50);
		if (gap > 0) begin
			point_valid <= 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1;
		@(posedge clk);
		while (!cfg_take) @(posedge clk);
		cfg_valid <= 0;
		sb.write_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic drain();
		point_valid <= 0;
		while (sb.expected_results.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic send_xyz(input int x, input int y, input int z, input bit last);
		point_item_t p;
		p.point_x = 16'(x); p.point_y = 16'(y); p.point_z = 16'(z); p.last_point = last;
		send_point(p);
	endtask

	function automatic int pick_inside(int lo, int hi);
		if (hi - lo >= 2) return lo + 1 + $urandom_range(0, hi - lo - 2);
		return $urandom_range(0, 65535) - 32768;
	endfunction

	function automatic int pick_coord(int mode, int lo, int hi);
		int r;
		int unsigned span;
		span = (sb.radius_mm > 0) ? sb.radius_mm : 1500;
		r = $urandom_range(0, 99);
		if (mode == 1 && r < 85) return pick_inside(lo, hi);
		if (r < 45) return $urandom_range(0, 2 * span) - int'(span);
		if (r < 55) begin
			case ($urandom_range(0, 4))
				0: return -32768;
				1: return 32767;
				2: return -1;
				3: return 1;
				default: return 0;
			endcase
		end
		if (r < 75) return pick_inside(lo, hi);
		return $urandom_range(0, 65535) - 32768;
	endfunction

	task automatic random_scans(input int n_items);
		int sent, len, mode, i;
		sent = 0;
		while (sent < n_items) begin
			mode = ($urandom_range(0, 3) == 0) ? 1 : 0;
			len = (mode == 1) ? $urandom_range(8, 20) : $urandom_range(1, 16);
			for (i = 0; i < len; i++) begin
				send_xyz(pick_coord(mode, sb.box_lo_x, sb.box_hi_x),
					pick_coord(mode, sb.box_lo_y, sb.box_hi_y),
					pick_coord(mode, sb.box_lo_z, sb.box_hi_z), i == len - 1);
			end
			sent += len;
		end
	endtask

	function automatic void pick_bounds(input int box_mode, output int lo, output int hi);
		if (box_mode == 0) begin
			lo = -32768; hi = 32767;
		end else if (box_mode == 1) begin
			lo = $urandom_range(0, 1200) - 800; hi = lo + $urandom_range(2, 1500);
		end else begin
			lo = $urandom_range(0, 65535) - 32768; hi = $urandom_range(0, 65535) - 32768;
		end
	endfunction

	task automatic load_settings(input int box_mode, input int radius, input int gain);
		int lo, hi;
		pick_bounds(box_mode, lo, hi);
		write_reg(CFG_BOX_MIN_X, lo[15:0]);
		write_reg(CFG_SEARCH_MAX_X, hi[15:0]);
		pick_bounds(box_mode, lo, hi);
		write_reg(CFG_BOX_MIN_Y, lo[15:0]);
		write_reg(CFG_BOX_MAX_Y, hi[15:0]);
		pick_bounds(box_mode, lo, hi);
		write_reg(CFG_BOX_MIN_Z, lo[15:0]);
		write_reg(CFG_BOX_MAX_Z, hi[15:0]);
		write_reg(CFG_INFL_RADIUS, radius[15:0]);
		write_reg(CFG_REPUL_GAIN, gain[15:0]);
	endtask

	initial begin
		int i, ph;
		sb = new();
		arst_n = 0;
		point_valid = 0;
		point = '0;
		cfg_valid = 0;
		cfg_index = '0;
		cfg_data = '0;
		calm = 0;
		hold_req = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send_xyz(0, 0, 0, 0);
		send_xyz(500, 0, 100, 0);
		send_xyz(1, 0, 0, 0);
		send_xyz(0, -1, 0, 0);
		send_xyz(999, 0, 0, 0);
		send_xyz(1000, 0, 0, 0);
		send_xyz(32767, 32767, 32767, 0);
		send_xyz(-32768, -32768, -32768, 0);
		send_xyz(-500, 400, -300, 0);
		send_xyz(300, 0, 100, 0);
		send_xyz(799, -299, 1499, 1);
		send_xyz(0, 0, 0, 1);
		for (i = 0; i < 12; i++) send_xyz(400 + 10 * i, -5 * i, 100, i == 11);
		drain();

		for (ph = 0; ph < 12; ph++) begin
			case (ph)
				0: load_settings(1, 0, 256);
				1: load_settings(0, 32767, 65535);
				2: load_settings(1, 1500, 0);
				3: load_settings(2, 1, 1);
				4: load_settings(1, 32767, 256);
				default: load_settings($urandom_range(0, 2), $urandom_range(1, 4000),
					$urandom_range(0, 65535));
			endcase
			calm = (ph == 6);
			if (ph == 8) hold_req = 1;
			random_scans(150);
			drain();
		end

		if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
`default_nettype wire

[sim.f]
rtl/core/srfa_pkg.sv
rtl/core/srfa_div.sv
rtl/core/srfa_sqrt.sv
rtl/core/srfa_dp.sv
rtl/core/srfa_ctrl.sv
rtl/core/scan_repulsive_force_accumulator.sv
rtl/core/srfa_checker.sv
dv/scan_repulsive_force_accumulator_test.sv
